// ===== src/lsp_pkg.sv =====
// Package for the link-state shortest-path engine: sizes, opcodes, controller states,
// the controller/datapath command and status structs, and the link-table address helper.
// Has no dependencies.
package lsp_pkg;

    localparam int NODES     = 16;
    localparam int COST_BITS = 16;

    localparam int NODE_W    = $clog2(NODES);
    localparam int LINKS     = NODES * NODES;
    localparam int LINK_AW   = $clog2(LINKS);
    localparam int PATH_W    = 20;
    localparam int SUM_W     = ((PATH_W > COST_BITS) ? PATH_W : COST_BITS) + 1;
    localparam int OUT_COUNT = (NODES < 16) ? NODES : 16;

    localparam logic [PATH_W-1:0] PATH_MAX = '1;

    // Field widths on the ports
    localparam int OP_W       = 2;
    localparam int IDX_W      = 4;
    localparam int IN_COST_W  = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_SET     = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_COMPUTE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RELAX,
        ST_DRAIN,
        ST_SELECT,
        ST_EMIT
    } st_t;

    typedef struct packed {
        logic              upd;     // apply a table op from the input item
        logic              start;   // begin a route computation
        logic              issue;   // read link pair (u, idx) / (idx, u)
        logic              settle;  // settle the best candidate
        logic              emit;    // load route entry idx into the output register
        logic              last;    // entry being loaded is the final one
        logic [NODE_W-1:0] idx;
    } lsp_cmd_t;

    typedef struct packed {
        logic src_ok;    // self node is inside the table
        logic found;     // a candidate was found in the last pass
        logic out_free;  // output register can take an entry this cycle
    } lsp_stat_t;

    function automatic logic [LINK_AW-1:0] link_addr(input logic [NODE_W-1:0] u,
                                                     input logic [NODE_W-1:0] v);
        return LINK_AW'(int'(u) * NODES + int'(v));
    endfunction

endpackage

// ===== src/lsp_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module lsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== src/lsp_ctrl.sv =====
// Controller for the shortest-path engine: accepts items, sequences the
// relax/select passes and the route-table emission. Depends on lsp_pkg.
module lsp_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  lsp_pkg::op_t       in_op,
    input  lsp_pkg::lsp_stat_t stat,
    output lsp_pkg::lsp_cmd_t  cmd
);
    import lsp_pkg::*;

    st_t               state_reg, state_next;
    logic [NODE_W-1:0] cnt_reg, cnt_next;
    logic              accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_tready   = 1'b0;
        accept     = 1'b0;
        cmd        = '0;
        cmd.idx    = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                accept   = s_tvalid;
                if (accept) begin
                    if (in_op == OP_COMPUTE) begin
                        cmd.start  = 1'b1;
                        cnt_next   = '0;
                        state_next = stat.src_ok ? ST_RELAX : ST_EMIT;
                    end else begin
                        cmd.upd = 1'b1;
                    end
                end
            end
            ST_RELAX: begin
                cmd.issue = 1'b1;
                if (cnt_reg == NODE_W'(NODES - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                // last pair of the pass is folded in at this edge
                state_next = ST_SELECT;
            end
            ST_SELECT: begin
                cmd.settle = 1'b1;
                cnt_next   = '0;
                state_next = stat.found ? ST_RELAX : ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.last = (cnt_reg == NODE_W'(OUT_COUNT - 1));
                    if (cmd.last) begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/lsp_dpath.sv =====
// Datapath for the shortest-path engine: link table (valid flops plus cost RAM),
// tentative costs, settle/best tracking and the output register. Depends on lsp_pkg, lsp_ram.
module lsp_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lsp_pkg::lsp_cmd_t             cmd,
    output lsp_pkg::lsp_stat_t            stat,
    input  lsp_pkg::op_t                  in_op,
    input  logic [lsp_pkg::IDX_W-1:0]     in_origin,
    input  logic [lsp_pkg::IDX_W-1:0]     in_peer,
    input  logic [lsp_pkg::IN_COST_W-1:0] in_cost,
    input  logic [lsp_pkg::IDX_W-1:0]     self_node,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [lsp_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import lsp_pkg::*;

    // link table
    logic [LINKS-1:0]     lv_reg, lv_next;
    logic [NODE_W-1:0]    org_n, peer_n;
    logic                 org_ok, peer_ok;
    logic [COST_BITS-1:0] set_cost;
    logic                 ram_we;
    logic [COST_BITS-1:0] w_uv, w_vu;

    // search state
    logic [NODE_W-1:0] u_reg, hu_reg, src_reg;
    logic [PATH_W-1:0] du_reg;
    logic              u_src_reg;
    logic [NODES-1:0]  seen_reg, settled_reg;
    logic              p_valid_reg;
    logic [NODE_W-1:0] p_v_reg;
    logic              found_reg;
    logic [NODE_W-1:0] best_reg, best_hop_reg;
    logic [PATH_W-1:0] best_cost_reg;

    logic [PATH_W-1:0] dist_reg [NODES];
    logic [NODE_W-1:0] hop_reg  [NODES];

    // relax stage
    logic [NODE_W-1:0]    rd_idx;
    logic [PATH_W-1:0]    dist_rd;
    logic [NODE_W-1:0]    hop_rd;
    logic                 edge_ok, upd, new_seen, take_best;
    logic [COST_BITS-1:0] edge_w;
    logic [SUM_W-1:0]     sum;
    logic [PATH_W-1:0]    cand, new_cost;
    logic [NODE_W-1:0]    new_hop;

    // output register
    logic              m_valid_reg;
    logic [IDX_W-1:0]  m_dest_reg, m_hop_reg;
    logic              m_reach_reg, m_last_reg;
    logic [PATH_W-1:0] m_cost_reg;
    logic              reach;

    // ---------------- table update ----------------
    assign org_ok   = int'(in_origin) < NODES;
    assign peer_ok  = int'(in_peer) < NODES;
    assign org_n    = NODE_W'(in_origin);
    assign peer_n   = NODE_W'(in_peer);
    assign set_cost = COST_BITS'(in_cost);
    assign ram_we   = cmd.upd && in_op == OP_SET && org_ok && peer_ok && set_cost != '0;

    always_comb begin
        lv_next = lv_reg;
        if (cmd.upd) begin
            unique case (in_op)
                OP_SET, OP_REMOVE: begin
                    if (org_ok && peer_ok) begin
                        lv_next[link_addr(org_n, peer_n)] = ram_we;
                    end
                end
                OP_CLEAR: begin
                    if (org_ok) begin
                        for (int k = 0; k < NODES; k++) begin
                            lv_next[link_addr(org_n, NODE_W'(k))] = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    lsp_ram #(
        .WIDTH (COST_BITS),
        .DEPTH (LINKS)
    ) u_cost_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (link_addr(org_n, peer_n)),
        .wdata   (set_cost),
        .raddr_a (link_addr(u_reg, cmd.idx)),
        .rdata_a (w_uv),
        .raddr_b (link_addr(cmd.idx, u_reg)),
        .rdata_b (w_vu)
    );

    // ---------------- relax / best tracking ----------------
    assign rd_idx  = cmd.emit ? cmd.idx : p_v_reg;
    assign dist_rd = dist_reg[rd_idx];
    assign hop_rd  = hop_reg[rd_idx];

    assign edge_ok = p_valid_reg && !settled_reg[p_v_reg]
                     && lv_reg[link_addr(u_reg, p_v_reg)]
                     && lv_reg[link_addr(p_v_reg, u_reg)];
    assign edge_w  = (w_uv > w_vu) ? w_uv : w_vu;
    assign sum     = SUM_W'(du_reg) + SUM_W'(edge_w);
    assign cand    = (sum > SUM_W'(PATH_MAX)) ? PATH_MAX : PATH_W'(sum);
    // strictly cheaper only, so the earliest path wins ties
    assign upd      = edge_ok && (!seen_reg[p_v_reg] || cand < dist_rd);
    assign new_cost = upd ? cand : dist_rd;
    assign new_hop  = upd ? (u_src_reg ? p_v_reg : hu_reg) : hop_rd;
    assign new_seen = seen_reg[p_v_reg] || upd;
    // ascending scan with strict compare keeps the lowest index on ties
    assign take_best = p_valid_reg && !settled_reg[p_v_reg] && new_seen
                       && (!found_reg || new_cost < best_cost_reg);

    always_ff @(posedge aclk) begin
        if (upd) begin
            dist_reg[p_v_reg] <= cand;
            hop_reg[p_v_reg]  <= new_hop;
        end
        if (take_best) begin
            best_reg      <= p_v_reg;
            best_cost_reg <= new_cost;
            best_hop_reg  <= new_hop;
        end
        p_v_reg <= cmd.idx;
        if (cmd.start) begin
            u_reg   <= NODE_W'(self_node);
            src_reg <= NODE_W'(self_node);
            du_reg  <= '0;
        end else if (cmd.settle && found_reg) begin
            u_reg  <= best_reg;
            du_reg <= best_cost_reg;
            hu_reg <= best_hop_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lv_reg      <= '0;
            seen_reg    <= '0;
            settled_reg <= '0;
            p_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
            u_src_reg   <= 1'b0;
        end else begin
            lv_reg      <= lv_next;
            p_valid_reg <= cmd.issue;
            if (cmd.start) begin
                seen_reg    <= '0;
                settled_reg <= '0;
                found_reg   <= 1'b0;
                u_src_reg   <= 1'b1;
                if (stat.src_ok) begin
                    seen_reg[NODE_W'(self_node)]    <= 1'b1;
                    settled_reg[NODE_W'(self_node)] <= 1'b1;
                end
            end else if (cmd.settle) begin
                found_reg <= 1'b0;
                if (found_reg) begin
                    settled_reg[best_reg] <= 1'b1;
                    u_src_reg             <= 1'b0;
                end
            end else begin
                if (upd) begin
                    seen_reg[p_v_reg] <= 1'b1;
                end
                if (take_best) begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // ---------------- output register ----------------
    assign reach = settled_reg[cmd.idx] && cmd.idx != src_reg;

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_dest_reg  <= IDX_W'(cmd.idx);
            m_reach_reg <= reach;
            m_cost_reg  <= reach ? dist_rd : '0;
            m_hop_reg   <= reach ? IDX_W'(hop_rd) : '0;
            m_last_reg  <= cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {3'b000, m_hop_reg, m_cost_reg, m_reach_reg, m_dest_reg};

    assign stat.src_ok   = int'(self_node) < NODES;
    assign stat.found    = found_reg;
    assign stat.out_free = !m_valid_reg || m_tready;

endmodule

// ===== src/link_state_shortest_path_top.sv =====
// Link-state shortest-path engine, top level.
// Table ops (set, remove, clear origin): one item per cycle, no result, done at accept.
// Compute: up to NODES passes (one link-pair read per cycle from the cost RAM for each
//   node index, then drain and select), then OUT_COUNT route items, one per cycle when
//   m_tready stays high. No new item is taken meanwhile.
// Reset (aresetn low, synchronous): all links invalid at once, self_node 0, no clear pass.
module link_state_shortest_path_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration: self node
    input  logic                           cfg_we,
    input  logic [lsp_pkg::IDX_W-1:0]      cfg_wdata,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lsp_pkg::IN_DATA_W-1:0]  s_tdata,   // [3:0] origin_node, [7:4] peer_node,
                                                      // [23:8] link_cost
    input  logic [lsp_pkg::OP_W-1:0]       s_tuser,   // [1:0] opcode
    // route items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lsp_pkg::OUT_DATA_W-1:0] m_tdata,   // [3:0] dest_node, [4] reachable,
                                                      // [24:5] path_cost, [28:25] first hop,
                                                      // rest 0
    output logic                           m_tlast    // last
);
    import lsp_pkg::*;

    lsp_cmd_t         cmd;
    lsp_stat_t        stat;
    op_t              in_op;
    logic [IDX_W-1:0] self_node_reg;

    // Self node register; the user must write it only while the engine is idle (not enforced here).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            self_node_reg <= '0;
        end else if (cfg_we) begin
            self_node_reg <= cfg_wdata;
        end
    end

    assign in_op = op_t'(s_tuser);

    // Controller: accepts items, runs the relax/select passes, paces emission.
    lsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_op    (in_op),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: link table, tentative costs and the output register.
    lsp_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_op     (in_op),
        .in_origin (s_tdata[3:0]),
        .in_peer   (s_tdata[7:4]),
        .in_cost   (s_tdata[23:8]),
        .self_node (self_node_reg),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
